// ----- sv/ssp_pkg.sv -----
// Package for the slew-limited servo pulse block.
// Holds the opcodes, register indexes, configuration type, stage words and fixed constants.
// No dependencies.
package ssp_pkg;

  typedef enum logic {
    OpSetTarget = 1'b0,
    OpTick      = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CfgEnabled   = 3'd0,
    CfgMinPulse  = 3'd1,
    CfgMaxPulse  = 3'd2,
    CfgDeadZone  = 3'd3,
    CfgStepSize  = 3'd4,
    CfgStepDelay = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] FullScale = 16'd46080;
  localparam logic [15:0] HomeAngle = 16'd20992;

  // Reciprocals for exact truncating division: x / 45 for x below 2**19 and
  // x / 625 for x below 2**23.
  localparam logic [26:0] Recip45  = 27'd95443718;
  localparam logic [30:0] Recip625 = 31'd1759218605;

  typedef struct packed {
    logic        enabled;
    logic [9:0]  min_pulse_us;
    logic [11:0] max_pulse_us;
    logic [15:0] dead_zone;
    logic [15:0] step_size;
    logic [15:0] step_delay_ms;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    enabled:       1'b0,
    min_pulse_us:  10'd500,
    max_pulse_us:  12'd2500,
    dead_zone:     16'd256,
    step_size:     16'd256,
    step_delay_ms: 16'd20
  };

  typedef struct packed {
    op_e         opcode;
    logic [15:0] target_angle;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic signed [21:0] prod;
    logic [15:0]        angle;
  } prod_word_t;

  typedef struct packed {
    logic [11:0] pulse_us;
    logic [15:0] angle;
  } pulse_word_t;

endpackage

// ----- sv/ssp_stream_if.sv -----
// Stream interfaces for the input words and the result words of the servo pulse block.
// Valid/ready handshake; a word moves when both are high at a rising edge. No dependencies.
interface ssp_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] target_angle;
  logic [31:0] now_ms;

  modport source (output valid, opcode, target_angle, now_ms, input ready);
  modport sink (input valid, opcode, target_angle, now_ms, output ready);
endinterface

interface ssp_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pulse_us;
  logic [13:0] duty;
  logic [15:0] angle_now;

  modport source (output valid, pulse_us, duty, angle_now, input ready);
  modport sink (input valid, pulse_us, duty, angle_now, output ready);
endinterface

// ----- sv/ssp_cfg.sv -----
// Configuration registers of the servo pulse block.
// Depends on ssp_pkg.
module ssp_cfg import ssp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgEnabled:   cfg_d.enabled       = cfg_data_i[0];
        CfgMinPulse:  cfg_d.min_pulse_us  = cfg_data_i[9:0];
        CfgMaxPulse:  cfg_d.max_pulse_us  = cfg_data_i[11:0];
        CfgDeadZone:  cfg_d.dead_zone     = cfg_data_i;
        CfgStepSize:  cfg_d.step_size     = cfg_data_i;
        CfgStepDelay: cfg_d.step_delay_ms = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/ssp_core.sv -----
// Input register and angle state of the servo pulse block: target, current angle, step time.
// Depends on ssp_pkg and ssp_stream_if.
module ssp_core import ssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssp_in_if.sink      in_i,
  input  cfg_t        cfg_i,
  output logic        a_valid_o,
  output logic [15:0] a_angle_o,
  input  logic        a_ready_i
);

  logic        in_v_q, in_v_d;
  in_word_t    in_q;
  logic        a_v_q, a_v_d;
  logic [15:0] a_angle_q;
  logic [15:0] target_q, target_d;
  logic [15:0] cur_q, cur_d;
  logic [31:0] last_q, last_d;

  logic        a_free, in_adv, in_take, emit;
  logic [15:0] req_c, req_diff, cur_diff, step_angle;
  logic [31:0] elapsed;
  logic signed [17:0] cur_s, tgt_s, st_s, nxt_s, dif_s, adif_s;
  logic        snap;

  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign a_free    = !a_v_q || a_ready_i;
  assign in_adv    = in_v_q && a_free;
  assign in_i.ready = !in_v_q || a_free;
  assign in_take   = in_i.valid && in_i.ready;

  assign req_c    = (in_q.target_angle > FullScale) ? FullScale : in_q.target_angle;
  assign req_diff = abs_diff(req_c, target_q);
  assign cur_diff = abs_diff(cur_q, target_q);
  assign elapsed  = in_q.now_ms - last_q;

  assign cur_s  = $signed({2'b00, cur_q});
  assign tgt_s  = $signed({2'b00, target_q});
  assign st_s   = $signed({2'b00, cfg_i.step_size});
  assign nxt_s  = (cur_q < target_q) ? cur_s + st_s : cur_s - st_s;
  assign dif_s  = nxt_s - tgt_s;
  assign adif_s = dif_s[17] ? -dif_s : dif_s;
  assign snap   = (cfg_i.step_size != 16'd0) && (adif_s < st_s);
  assign step_angle = snap ? target_q : nxt_s[15:0];

  always_comb begin
    target_d = target_q;
    cur_d    = cur_q;
    last_d   = last_q;
    emit     = 1'b0;
    if (in_adv && cfg_i.enabled) begin
      if (in_q.opcode == OpSetTarget) begin
        if (req_diff > cfg_i.dead_zone) begin
          target_d = req_c;
        end
      end else if (cur_diff <= cfg_i.dead_zone) begin
        cur_d = target_q;
        emit  = 1'b1;
      end else if (elapsed >= {16'd0, cfg_i.step_delay_ms}) begin
        last_d = in_q.now_ms;
        cur_d  = step_angle;
        emit   = 1'b1;
      end
    end
  end

  assign in_v_d = in_take || (in_v_q && !in_adv);
  assign a_v_d  = in_adv ? emit : (a_v_q && !a_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      a_v_q    <= 1'b0;
      target_q <= HomeAngle;
      cur_q    <= HomeAngle;
      last_q   <= 32'd0;
    end else begin
      in_v_q   <= in_v_d;
      a_v_q    <= a_v_d;
      target_q <= target_d;
      cur_q    <= cur_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= '{opcode: op_e'(in_i.opcode), target_angle: in_i.target_angle,
                now_ms: in_i.now_ms};
    end
    if (in_adv && emit) begin
      a_angle_q <= cur_d;
    end
  end

  assign a_valid_o = a_v_q;
  assign a_angle_o = a_angle_q;

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (target_q <= FullScale) && (cur_q <= FullScale))
    else $error("Angle state left the 0 to 180 degree range.");

  a_set_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && in_q.opcode == OpSetTarget) |=> !a_v_q)
    else $error("A set-target word produced a result.");

  a_disabled_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && !cfg_i.enabled) |=> $stable(target_q) && $stable(cur_q) && $stable(last_q))
    else $error("State changed while the servo was disabled.");

  a_emit_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && emit) |=> a_v_q && (a_angle_q == cur_q))
    else $error("Emitted angle differs from the updated current angle.");

endmodule

// ----- sv/ssp_map.sv -----
// Angle to pulse width mapping: product stage, then truncating divide by 180 and clamp.
// Depends on ssp_pkg.
module ssp_map import ssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        a_valid_i,
  input  logic [15:0] a_angle_i,
  output logic        a_ready_o,
  output logic        us_valid_o,
  output pulse_word_t us_o,
  input  logic        us_ready_i
);

  logic        p_v_q, p_v_d, us_v_q, us_v_d;
  prod_word_t  p_q;
  pulse_word_t us_q;

  logic               p_free, us_free, p_take, p_adv;
  logic signed [8:0]  deg_s;
  logic signed [12:0] span_s;
  logic signed [21:0] prod, mag;
  logic [18:0]        quot_in;
  logic [45:0]        quot_prod;
  logic [13:0]        quot;
  logic signed [15:0] quot_s, us_s, lo_s, hi_s;
  logic [11:0]        us_clamp;

  assign us_free   = !us_v_q || us_ready_i;
  assign p_free    = !p_v_q || us_free;
  assign a_ready_o = p_free;
  assign p_take    = a_valid_i && p_free;
  assign p_adv     = p_v_q && us_free;

  assign deg_s  = $signed({1'b0, a_angle_i[15:8]});
  assign span_s = $signed({1'b0, cfg_i.max_pulse_us}) - $signed({3'b000, cfg_i.min_pulse_us});
  assign prod   = 22'(deg_s) * 22'(span_s);

  assign mag       = p_q.prod[21] ? -p_q.prod : p_q.prod;
  assign quot_in   = mag[20:2];
  assign quot_prod = 46'(quot_in) * 46'(Recip45);
  assign quot      = quot_prod[45:32];
  assign quot_s    = p_q.prod[21] ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
  assign lo_s      = $signed({6'd0, cfg_i.min_pulse_us});
  assign hi_s      = $signed({4'd0, cfg_i.max_pulse_us});
  assign us_s      = quot_s + lo_s;

  always_comb begin
    if (us_s < lo_s) begin
      us_clamp = {2'b00, cfg_i.min_pulse_us};
    end else if (us_s > hi_s) begin
      us_clamp = cfg_i.max_pulse_us;
    end else begin
      us_clamp = us_s[11:0];
    end
  end

  assign p_v_d  = p_take || (p_v_q && !us_free);
  assign us_v_d = p_adv || (us_v_q && !us_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q  <= 1'b0;
      us_v_q <= 1'b0;
    end else begin
      p_v_q  <= p_v_d;
      us_v_q <= us_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_take) begin
      p_q <= '{prod: prod, angle: a_angle_i};
    end
    if (p_adv) begin
      us_q <= '{pulse_us: us_clamp, angle: p_q.angle};
    end
  end

  assign us_valid_o = us_v_q;
  assign us_o       = us_q;

endmodule

// ----- sv/ssp_duty.sv -----
// Duty computation and result register: duty = pulse_us * 65535 / 20000, truncated.
// Depends on ssp_pkg and ssp_stream_if.
module ssp_duty import ssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        us_valid_i,
  input  pulse_word_t us_i,
  output logic        us_ready_o,
  ssp_out_if.source   out_o
);

  logic        out_v_q, out_v_d, take;
  logic [11:0] pulse_q;
  logic [13:0] duty_q;
  logic [15:0] angle_q;
  logic [27:0] scaled;
  logic [53:0] duty_prod;

  assign us_ready_o = !out_v_q || out_o.ready;
  assign take       = us_valid_i && us_ready_o;
  assign out_v_d    = take || (out_v_q && !out_o.ready);

  // Times 65535 is a shift and a subtract; the divide by 20000 is a shift by 5
  // and a reciprocal multiply for 625.
  assign scaled    = {us_i.pulse_us, 16'd0} - {16'd0, us_i.pulse_us};
  assign duty_prod = 54'(scaled[27:5]) * 54'(Recip625);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pulse_q <= us_i.pulse_us;
      duty_q  <= duty_prod[53:40];
      angle_q <= us_i.angle;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.pulse_us  = pulse_q;
  assign out_o.duty      = duty_q;
  assign out_o.angle_now = angle_q;

endmodule

// ----- sv/servo_slew_limited_pulse_top.sv -----
// Top level of the slew-limited servo pulse block.
// Depends on ssp_pkg, ssp_stream_if, ssp_cfg, ssp_core, ssp_map and ssp_duty.
//
// Channel   Direction  Word
// in_i      sink       opcode, target_angle, now_ms
// out_o     source     pulse_us, duty, angle_now
// cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// One word is accepted per cycle while the output does not stall; a word that yields a result
// passes the input register, state update, product, divide and clamp, and duty multiply on its
// way to the result register. Reset clears the pipeline valids and returns the angle state and
// the configuration registers to their reset values; there is no clearing pass. A stalled output
// holds each stage that is full, while empty stages upstream keep taking words.
module servo_slew_limited_pulse_top import ssp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  ssp_in_if.sink              in_i,
  ssp_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t        cfg;
  logic        a_valid, a_ready;
  logic [15:0] a_angle;
  logic        us_valid, us_ready;
  pulse_word_t us_word;

  ssp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ssp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg),
    .a_valid_o (a_valid),
    .a_angle_o (a_angle),
    .a_ready_i (a_ready)
  );

  ssp_map u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .a_valid_i  (a_valid),
    .a_angle_i  (a_angle),
    .a_ready_o  (a_ready),
    .us_valid_o (us_valid),
    .us_o       (us_word),
    .us_ready_i (us_ready)
  );

  ssp_duty u_duty (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .us_valid_i (us_valid),
    .us_i       (us_word),
    .us_ready_o (us_ready),
    .out_o      (out_o)
  );

endmodule

// ----- tb/sv/ssp_checker.sv -----
// Checker for the slew-limited servo pulse block: watches the word channels and the register
// port, predicts every pulse word from its own copy of the servo state and compares in order.
// Depends on ssp_pkg and ssp_stream_if.
module ssp_checker import ssp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  ssp_in_if                   in_i,
  ssp_out_if                  out_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  errors_o,
  output int                  waiting_o,
  output int                  words_o,
  output int                  ticks_o,
  output int                  pulses_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] pulse_us;
    logic [13:0] duty;
    logic [15:0] angle_now;
  } pulse_t;

  cfg_t        regs;
  logic [15:0] target;
  logic [15:0] angle;
  logic [31:0] last_step_ms;
  pulse_t      due_pulses[$];
  int          errors;
  int          words;
  int          ticks;
  int          pulses;

  function automatic int unsigned angle_gap(logic [15:0] a, logic [15:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void emit_pulse();
    int          deg;
    int          lo;
    int          hi;
    int          us;
    logic [31:0] scaled;
    pulse_t      p;
    deg = int'(angle[15:8]);
    lo  = int'(regs.min_pulse_us);
    hi  = int'(regs.max_pulse_us);
    us  = deg * (hi - lo) / 180 + lo;
    if (us < lo) begin
      us = lo;
    end else if (us > hi) begin
      us = hi;
    end
    p.pulse_us  = us[11:0];
    scaled      = 32'(p.pulse_us) * 32'd65535 / 32'd20000;
    p.duty      = scaled[13:0];
    p.angle_now = angle;
    due_pulses.push_back(p);
  endfunction

  function automatic void advance_servo(op_e op, logic [15:0] req, logic [31:0] now_ms);
    logic [15:0] clamped;
    logic [31:0] elapsed;
    int          cur;
    int          tgt;
    int          st;
    int          gap;
    if (!regs.enabled) return;
    if (op == OpSetTarget) begin
      clamped = (req > FullScale) ? FullScale : req;
      if (angle_gap(clamped, target) > regs.dead_zone) target = clamped;
    end else if (angle_gap(angle, target) <= regs.dead_zone) begin
      angle = target;
      emit_pulse();
    end else begin
      elapsed = now_ms - last_step_ms;
      if (elapsed >= 32'(regs.step_delay_ms)) begin
        last_step_ms = now_ms;
        cur  = int'(angle);
        tgt  = int'(target);
        st   = int'(regs.step_size);
        cur  = (cur < tgt) ? cur + st : cur - st;
        gap  = (cur > tgt) ? cur - tgt : tgt - cur;
        if (st > 0 && gap < st) cur = tgt;
        angle = cur[15:0];
        emit_pulse();
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pulse_t want;
    if (!rst_ni) begin
      regs         = CfgReset;
      target       = HomeAngle;
      angle        = HomeAngle;
      last_step_ms = '0;
      due_pulses.delete();
      errors       = 0;
      words        = 0;
      ticks        = 0;
      pulses       = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        pulses++;
        if (due_pulses.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected pulse word: pulse_us %0d duty %0d angle_now %0d",
                     out_i.pulse_us, out_i.duty, out_i.angle_now);
          end
        end else begin
          want = due_pulses.pop_front();
          if (out_i.pulse_us != want.pulse_us || out_i.duty != want.duty ||
              out_i.angle_now != want.angle_now) begin
            errors++;
            if (errors <= 10) begin
              $display("pulse word %0d: expected pulse_us %0d duty %0d angle_now %0d, got %0d %0d %0d",
                       pulses, want.pulse_us, want.duty, want.angle_now,
                       out_i.pulse_us, out_i.duty, out_i.angle_now);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgEnabled:   regs.enabled       = cfg_data_i[0];
          CfgMinPulse:  regs.min_pulse_us  = cfg_data_i[9:0];
          CfgMaxPulse:  regs.max_pulse_us  = cfg_data_i[11:0];
          CfgDeadZone:  regs.dead_zone     = cfg_data_i;
          CfgStepSize:  regs.step_size     = cfg_data_i;
          CfgStepDelay: regs.step_delay_ms = cfg_data_i;
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        words++;
        if (in_i.opcode == OpTick) ticks++;
        advance_servo(op_e'(in_i.opcode), in_i.target_angle, in_i.now_ms);
      end
    end
    errors_o  <= errors;
    waiting_o <= due_pulses.size();
    words_o   <= words;
    ticks_o   <= ticks;
    pulses_o  <= pulses;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for servo_slew_limited_pulse_top: clock, reset, register writes, word stimulus
// and output stalls; the verdict comes from the failure and outstanding pulse counts of ssp_checker.
// Depends on ssp_pkg, ssp_stream_if, ssp_checker and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ssp_pkg::*;

  localparam int CycleLimit = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int                  errors;
  int                  waiting;
  int                  words;
  int                  ticks;
  int                  pulses;
  int                  cycles = 0;
  int                  settings;
  cfg_t                servo_cfg;
  logic [31:0]         now_ms;
  logic [15:0]         aim;
  bit                  idle_on;
  bit                  hold_req;

  ssp_in_if  in_ch ();
  ssp_out_if out_ch ();

  servo_slew_limited_pulse_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  ssp_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_i      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .errors_o   (errors),
    .waiting_o  (waiting),
    .words_o    (words),
    .ticks_o    (ticks),
    .pulses_o   (pulses)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Run timed out after %0d cycles with %0d pulse words outstanding.", cycles, waiting);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        for (int k = 0; k < 250; k++) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  function automatic cfg_t servo_setting(int lo, int hi, int dz, int st, int dly);
    cfg_t c;
    c.enabled       = 1'b1;
    c.min_pulse_us  = 10'(lo);
    c.max_pulse_us  = 12'(hi);
    c.dead_zone     = 16'(dz);
    c.step_size     = 16'(st);
    c.step_delay_ms = 16'(dly);
    return c;
  endfunction

  function automatic cfg_t random_setting();
    return servo_setting($urandom_range(500, 1000), $urandom_range(2000, 2550),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 46080)
                                                     : $urandom_range(0, 600),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 46080)
                                                     : $urandom_range(1, 2000),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 50));
  endfunction

  task automatic put_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic load_regs(cfg_t c);
    servo_cfg = c;
    settings++;
    put_reg(CfgEnabled,   {15'($urandom), c.enabled});
    put_reg(CfgMinPulse,  {6'($urandom), c.min_pulse_us});
    put_reg(CfgMaxPulse,  {4'($urandom), c.max_pulse_us});
    put_reg(CfgDeadZone,  c.dead_zone);
    put_reg(CfgStepSize,  c.step_size);
    put_reg(CfgStepDelay, c.step_delay_ms);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_word(op_e op, logic [15:0] angle_req, logic [31:0] stamp);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.target_angle <= angle_req;
    in_ch.now_ms       <= stamp;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (waiting != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_words(int count);
    int          roll;
    logic [31:0] span;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      span = 32'(servo_cfg.step_delay_ms);
      if (roll < 20) begin
        case ($urandom_range(0, 3))
          0: aim = 16'($urandom_range(0, 46080));
          1: aim = 16'($urandom);
          2: aim = aim + 16'($urandom_range(0, 2 * servo_cfg.dead_zone + 2))
                   - servo_cfg.dead_zone - 16'd1;
          default: aim = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
        endcase
        send_word(OpSetTarget, aim, 32'($urandom));
      end else if (roll < 92) begin
        case ($urandom_range(0, 7))
          0: now_ms = now_ms + span + 32'($urandom_range(0, 2)) - 32'd1;
          1: now_ms = 32'($urandom);
          default: now_ms = now_ms + span + 32'($urandom_range(0, 3));
        endcase
        send_word(OpTick, 16'($urandom), now_ms);
      end else begin
        send_word(op_e'($urandom_range(0, 1)), 16'($urandom), 32'($urandom));
      end
    end
  endtask

  initial begin
    cfg_t c;
    rst_ni             <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OpSetTarget;
    in_ch.target_angle <= '0;
    in_ch.now_ms       <= '0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CfgEnabled;
    cfg_data_i         <= '0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    now_ms   = '0;
    aim      = HomeAngle;
    settings = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The servo is detached after reset, so every word must be dropped.
    load_regs(CfgReset);
    send_word(OpSetTarget, 16'd0, 32'd0);
    send_word(OpTick, 16'hFFFF, 32'd100);
    random_words(40);
    settle();

    c = CfgReset;
    c.enabled = 1'b1;
    load_regs(c);
    send_word(OpTick, 16'd0, 32'd0);
    send_word(OpSetTarget, 16'hFFFF, 32'd0);
    send_word(OpTick, 16'd0, 32'd19);
    send_word(OpTick, 16'd0, 32'd20);
    send_word(OpSetTarget, FullScale + 16'd100, 32'd0);
    send_word(OpTick, 16'd0, 32'hFFFF_FFFF);
    send_word(OpTick, 16'd0, 32'd18);
    send_word(OpTick, 16'd0, 32'd19);
    send_word(OpSetTarget, 16'd0, 32'd0);
    send_word(OpTick, 16'd0, 32'h7FFF_FFFF);
    now_ms = 32'h7FFF_FFFF;
    random_words(150);
    settle();

    load_regs(servo_setting(1000, 2000, 0, 1, 0));
    random_words(150);
    settle();

    // Every tick lands inside the dead zone here, so the output backs up during the hold.
    load_regs(servo_setting(500, 2550, 46080, 46080, 65535));
    idle_on  = 1'b0;
    hold_req = 1'b1;
    random_words(120);
    settle();
    idle_on = 1'b1;

    // Crossed pulse limits with a zero step: the angle holds while pulses still go out.
    load_regs(servo_setting(1000, 600, 16, 0, 5));
    send_word(OpSetTarget, FullScale, now_ms);
    now_ms = now_ms + 32'd10;
    send_word(OpTick, 16'd0, now_ms);
    now_ms = now_ms + 32'd10;
    send_word(OpTick, 16'd0, now_ms);
    send_word(OpSetTarget, 16'd0, now_ms);
    now_ms = now_ms + 32'd10;
    send_word(OpTick, 16'd0, now_ms);
    now_ms = now_ms + 32'd10;
    send_word(OpTick, 16'd0, now_ms);
    random_words(120);
    settle();

    load_regs(servo_setting(0, 4095, 0, 65535, 1));
    random_words(100);
    settle();

    for (int p = 0; p < 4; p++) begin
      load_regs(random_setting());
      random_words(150);
      settle();
    end

    c = random_setting();
    c.enabled = 1'b0;
    load_regs(c);
    random_words(30);
    settle();

    idle_on = 1'b0;
    load_regs(random_setting());
    random_words(200);
    settle();

    $display("Covered %0d input words, %0d of them update ticks, and checked %0d pulse words",
             words, ticks, pulses);
    $display("across %0d register settings, detached, crossed and extreme limits among them.",
             settings);
    if (errors == 0 && waiting == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
